/* hdl/escaped_word_frame_deframer_defines.svh */
// ----------------------------------------------------------------------------
// Escaped word frame deframer: assertion macros
// Shared property macros for the checker of the deframer ports.
// ----------------------------------------------------------------------------
`ifndef ESCAPED_WORD_FRAME_DEFRAMER_DEFINES_SVH
`define ESCAPED_WORD_FRAME_DEFRAMER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EWFD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define EWFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/ewfd_pkg.sv */
// ----------------------------------------------------------------------------
// Escaped word frame deframer package
// Link word codes, result kinds, widths and shared types.
// ----------------------------------------------------------------------------
package ewfd_pkg;

  localparam int WORD_W   = 16;
  localparam int LEN_W    = 11;
  localparam int POS_W    = 10;
  localparam int KIND_W   = 2;
  localparam int SLOT_OUT_W = 2;

  // Number of packet buffer slots used round-robin.
  localparam int SLOTS    = 4;
  localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [WORD_W-1:0] WORD_IDLE = 16'hFFFF;
  localparam logic [WORD_W-1:0] WORD_SOP  = 16'hFFAA;
  localparam logic [WORD_W-1:0] WORD_EOP  = 16'hFF55;
  localparam logic [WORD_W-1:0] WORD_ESC  = 16'h7FFF;
  localparam logic [WORD_W-1:0] ESC_FLIP  = 16'h4000;

  localparam logic [LEN_W-1:0] LEN_CAP          = 11'd1024;
  localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = 11'd400;

  localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_END     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ACK     = 2'd2;

  typedef struct packed {
    logic is_idle;
    logic is_sop;
    logic is_eop;
    logic is_esc;
  } word_class_t;

endpackage

/* hdl/ewfd_decode.sv */
// ----------------------------------------------------------------------------
// Link word decoder
// Recognizes the idle, start, end and escape codes in one link word.
// ----------------------------------------------------------------------------
module ewfd_decode (
  input  logic [ewfd_pkg::WORD_W-1:0] link_word,
  output ewfd_pkg::word_class_t       word_class
);

  always_comb begin
    word_class.is_idle = (link_word == ewfd_pkg::WORD_IDLE);
    word_class.is_sop  = (link_word == ewfd_pkg::WORD_SOP);
    word_class.is_eop  = (link_word == ewfd_pkg::WORD_EOP);
    word_class.is_esc  = (link_word == ewfd_pkg::WORD_ESC);
  end

endmodule

/* hdl/escaped_word_frame_deframer.sv */
// ----------------------------------------------------------------------------
// Escaped word frame deframer
// Splits a 16-bit link word stream into packet payload words, packet end
// reports and acknowledge pairs.
//
// Input channel: received_word with in_valid / in_stall, one link word per
// accepted word. Output channel: kind, slot, position, length, value,
// ack_code and ack_info with out_valid / out_stall; fields that do not
// belong to the kind are zero. At most one result per input word.
// max_length is loaded through cfg_we / cfg_data; the user must load it only
// while the block is idle, as the block itself does not enforce this. Words
// pass through two registers: the input register, then the result register.
// One word is accepted every cycle unless in_stall is high; the mode, slot
// and count update is combinational logic between those two registers. While
// out_stall holds a waiting result, an empty input register still takes one
// word, and in_stall is high whenever the input register is full.
// Reset (synchronous, rst high) empties both registers, returns to the
// acknowledge first word mode, clears slot, count and held code, and sets
// max_length to 400.
// ----------------------------------------------------------------------------
module escaped_word_frame_deframer (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [ewfd_pkg::LEN_W-1:0]            cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [ewfd_pkg::WORD_W-1:0]           received_word,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [ewfd_pkg::KIND_W-1:0]           kind,
  output logic [ewfd_pkg::SLOT_OUT_W-1:0]       slot,
  output logic [ewfd_pkg::POS_W-1:0]            position,
  output logic [ewfd_pkg::LEN_W-1:0]            length,
  output logic [ewfd_pkg::WORD_W-1:0]           value,
  output logic [ewfd_pkg::WORD_W-1:0]           ack_code,
  output logic [ewfd_pkg::WORD_W-1:0]           ack_info
);

  typedef enum logic [1:0] {
    MODE_ACK,
    MODE_ACK_INFO,
    MODE_DATA,
    MODE_ESCAPE
  } mode_t;

  localparam logic [ewfd_pkg::SLOT_W-1:0] SLOT_LAST = ewfd_pkg::SLOT_W'(ewfd_pkg::SLOTS - 1);

  // Input register.
  logic                          in_full;
  logic [ewfd_pkg::WORD_W-1:0]   in_word;

  // Deframer state.
  mode_t                         mode, mode_next;
  logic [ewfd_pkg::SLOT_W-1:0]   current_slot, current_slot_next;
  logic [ewfd_pkg::LEN_W-1:0]    word_count, word_count_next;
  logic [ewfd_pkg::WORD_W-1:0]   held_ack_code, held_ack_code_next;
  logic [ewfd_pkg::LEN_W-1:0]    max_length;

  ewfd_pkg::word_class_t         word_class;
  logic                          out_load;
  logic                          process;
  logic [ewfd_pkg::LEN_W-1:0]    len_limit;
  logic                          at_limit;
  logic                          store;
  logic [ewfd_pkg::WORD_W-1:0]   store_word;

  logic                          res_valid;
  logic [ewfd_pkg::KIND_W-1:0]   res_kind;
  logic [ewfd_pkg::SLOT_OUT_W-1:0] res_slot;
  logic [ewfd_pkg::POS_W-1:0]    res_position;
  logic [ewfd_pkg::LEN_W-1:0]    res_length;
  logic [ewfd_pkg::WORD_W-1:0]   res_value;
  logic [ewfd_pkg::WORD_W-1:0]   res_ack_code;
  logic [ewfd_pkg::WORD_W-1:0]   res_ack_info;

  ewfd_decode u_decode (
    .link_word  (in_word),
    .word_class (word_class)
  );

  assign out_load = !out_valid || !out_stall;
  assign process  = in_full && out_load;
  assign in_stall = in_full && !out_load;

  // Settings above the largest buffer act as the largest buffer.
  assign len_limit = (max_length > ewfd_pkg::LEN_CAP) ? ewfd_pkg::LEN_CAP : max_length;
  assign at_limit  = (word_count >= len_limit);

  always_comb begin
    mode_next          = mode;
    current_slot_next  = current_slot;
    word_count_next    = word_count;
    held_ack_code_next = held_ack_code;
    store              = 1'b0;
    store_word         = in_word;
    res_valid          = 1'b0;
    res_kind           = ewfd_pkg::KIND_PAYLOAD;
    res_slot           = '0;
    res_position       = '0;
    res_length         = '0;
    res_value          = '0;
    res_ack_code       = '0;
    res_ack_info       = '0;

    if (in_full && !word_class.is_idle) begin
      if (word_class.is_sop) begin
        // A start marker opens a packet from any mode, even after an escape.
        mode_next       = MODE_DATA;
        word_count_next = '0;
      end else begin
        case (mode)
          MODE_ACK: begin
            held_ack_code_next = in_word;
            mode_next          = MODE_ACK_INFO;
          end
          MODE_ACK_INFO: begin
            mode_next    = MODE_ACK;
            res_valid    = 1'b1;
            res_kind     = ewfd_pkg::KIND_ACK;
            res_ack_code = held_ack_code;
            res_ack_info = in_word;
          end
          MODE_DATA: begin
            if (word_class.is_eop) begin
              res_valid         = 1'b1;
              res_kind          = ewfd_pkg::KIND_END;
              res_slot          = ewfd_pkg::SLOT_OUT_W'(current_slot);
              res_length        = word_count;
              current_slot_next = (current_slot == SLOT_LAST) ? '0
                                : ewfd_pkg::SLOT_W'(current_slot + 1'b1);
              mode_next         = MODE_ACK;
            end else if (word_class.is_esc) begin
              mode_next = MODE_ESCAPE;
            end else begin
              store = 1'b1;
            end
          end
          MODE_ESCAPE: begin
            mode_next  = MODE_DATA;
            store      = 1'b1;
            store_word = in_word ^ ewfd_pkg::ESC_FLIP;
          end
          default: begin
            mode_next = MODE_ACK;
          end
        endcase

        // Payload past the length limit is dropped without a result.
        if (store && !at_limit) begin
          res_valid       = 1'b1;
          res_kind        = ewfd_pkg::KIND_PAYLOAD;
          res_slot        = ewfd_pkg::SLOT_OUT_W'(current_slot);
          res_position    = word_count[ewfd_pkg::POS_W-1:0];
          res_value       = store_word;
          word_count_next = ewfd_pkg::LEN_W'(word_count + 1'b1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full       <= 1'b0;
      out_valid     <= 1'b0;
      mode          <= MODE_ACK;
      current_slot  <= '0;
      word_count    <= '0;
      held_ack_code <= '0;
      max_length    <= ewfd_pkg::MAX_LENGTH_RESET;
    end else begin
      if (cfg_we) begin
        max_length <= cfg_data;
      end
      if (!in_stall) begin
        in_full <= in_valid;
        if (in_valid) begin
          in_word <= received_word;
        end
      end
      if (process) begin
        mode          <= mode_next;
        current_slot  <= current_slot_next;
        word_count    <= word_count_next;
        held_ack_code <= held_ack_code_next;
      end
      if (out_load) begin
        out_valid <= res_valid;
        kind      <= res_kind;
        slot      <= res_slot;
        position  <= res_position;
        length    <= res_length;
        value     <= res_value;
        ack_code  <= res_ack_code;
        ack_info  <= res_ack_info;
      end
    end
  end

endmodule

/* hdl/ewfd_checker.sv */
// ----------------------------------------------------------------------------
// Escaped word frame deframer port checker
// Watches the result port for held words and fields that match the kind.
// ----------------------------------------------------------------------------
`include "escaped_word_frame_deframer_defines.svh"

module ewfd_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input logic [ewfd_pkg::KIND_W-1:0]           kind,
  input logic [ewfd_pkg::SLOT_OUT_W-1:0]       slot,
  input logic [ewfd_pkg::POS_W-1:0]            position,
  input logic [ewfd_pkg::LEN_W-1:0]            length,
  input logic [ewfd_pkg::WORD_W-1:0]           value,
  input logic [ewfd_pkg::WORD_W-1:0]           ack_code,
  input logic [ewfd_pkg::WORD_W-1:0]           ack_info
);

  `EWFD_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(kind) && $stable(slot) && $stable(position) && $stable(length) && $stable(value) && $stable(ack_code) && $stable(ack_info), "stalled result word changed")

  `EWFD_ASSERT_SAME(a_kind_known, clk, rst, out_valid, kind == ewfd_pkg::KIND_PAYLOAD || kind == ewfd_pkg::KIND_END || kind == ewfd_pkg::KIND_ACK, "unknown result kind")

  `EWFD_ASSERT_SAME(a_payload_fields, clk, rst, out_valid && kind == ewfd_pkg::KIND_PAYLOAD, length == '0 && ack_code == '0 && ack_info == '0, "payload word carries foreign fields")

  `EWFD_ASSERT_SAME(a_end_fields, clk, rst, out_valid && kind == ewfd_pkg::KIND_END, position == '0 && value == '0 && ack_code == '0 && ack_info == '0 && length <= ewfd_pkg::LEN_CAP, "packet end word malformed")

  `EWFD_ASSERT_SAME(a_ack_fields, clk, rst, out_valid && kind == ewfd_pkg::KIND_ACK, slot == '0 && position == '0 && length == '0 && value == '0, "acknowledge word carries foreign fields")

endmodule

bind escaped_word_frame_deframer ewfd_checker u_ewfd_checker (.*);

/* test/escaped_word_frame_deframer_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Escaped word frame deframer checker
// Watches the link word channel, the result channel and the max_length port,
// keeps its own copy of the deframer state, and compares every accepted
// result, field by field, with the oldest predicted one.
// ----------------------------------------------------------------------------
module escaped_word_frame_deframer_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [ewfd_pkg::LEN_W-1:0]        cfg_data,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [ewfd_pkg::WORD_W-1:0]       received_word,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [ewfd_pkg::KIND_W-1:0]       kind,
  input  logic [ewfd_pkg::SLOT_OUT_W-1:0]   slot,
  input  logic [ewfd_pkg::POS_W-1:0]        position,
  input  logic [ewfd_pkg::LEN_W-1:0]        length,
  input  logic [ewfd_pkg::WORD_W-1:0]       value,
  input  logic [ewfd_pkg::WORD_W-1:0]       ack_code,
  input  logic [ewfd_pkg::WORD_W-1:0]       ack_info,
  output int                                fail_count,
  output logic                              drained
);

  typedef enum logic [1:0] {
    ACK_CODE_WAIT,
    ACK_INFO_WAIT,
    IN_PACKET,
    AFTER_ESCAPE
  } link_mode_t;

  typedef struct packed {
    logic [ewfd_pkg::KIND_W-1:0]     kind;
    logic [ewfd_pkg::SLOT_OUT_W-1:0] slot;
    logic [ewfd_pkg::POS_W-1:0]      position;
    logic [ewfd_pkg::LEN_W-1:0]      length;
    logic [ewfd_pkg::WORD_W-1:0]     value;
    logic [ewfd_pkg::WORD_W-1:0]     ack_code;
    logic [ewfd_pkg::WORD_W-1:0]     ack_info;
  } deframe_result_t;

  link_mode_t                  link_mode;
  int unsigned                 packet_slot;
  logic [ewfd_pkg::LEN_W-1:0]  kept_words;
  logic [ewfd_pkg::WORD_W-1:0] held_code;
  logic [ewfd_pkg::LEN_W-1:0]  length_limit;
  deframe_result_t             pending_results[$];
  int                          mismatches = 0;

  assign fail_count = mismatches;

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want_v, got_v);
      mismatches++;
    end
  endtask

  // Advances the predicted state by one accepted link word and queues the
  // result it causes, if any.
  task automatic deframe_word(input logic [ewfd_pkg::WORD_W-1:0] w);
    deframe_result_t             r;
    logic [ewfd_pkg::WORD_W-1:0] stored;
    logic [ewfd_pkg::LEN_W-1:0]  keep_limit;
    bit                          produced;
    bit                          store;
    r = '0;
    stored = '0;
    produced = 0;
    store = 0;
    if (w == ewfd_pkg::WORD_IDLE) begin
      // Idle words leave every mode alone, a pending escape included.
    end else if (w == ewfd_pkg::WORD_SOP) begin
      link_mode = IN_PACKET;
      kept_words = '0;
    end else begin
      case (link_mode)
        ACK_CODE_WAIT: begin
          held_code = w;
          link_mode = ACK_INFO_WAIT;
        end
        ACK_INFO_WAIT: begin
          link_mode = ACK_CODE_WAIT;
          r.kind = ewfd_pkg::KIND_ACK;
          r.ack_code = held_code;
          r.ack_info = w;
          produced = 1;
        end
        IN_PACKET: begin
          if (w == ewfd_pkg::WORD_EOP) begin
            r.kind = ewfd_pkg::KIND_END;
            r.slot = packet_slot[ewfd_pkg::SLOT_OUT_W-1:0];
            r.length = kept_words;
            produced = 1;
            packet_slot = (packet_slot + 1 >= ewfd_pkg::SLOTS) ? 0 : packet_slot + 1;
            link_mode = ACK_CODE_WAIT;
          end else if (w == ewfd_pkg::WORD_ESC) begin
            link_mode = AFTER_ESCAPE;
          end else begin
            stored = w;
            store = 1;
          end
        end
        default: begin
          link_mode = IN_PACKET;
          stored = w ^ ewfd_pkg::ESC_FLIP;
          store = 1;
        end
      endcase
    end
    if (store) begin
      keep_limit = (length_limit > ewfd_pkg::LEN_CAP) ? ewfd_pkg::LEN_CAP : length_limit;
      // Words past the limit vanish without any result.
      if (kept_words < keep_limit) begin
        r.kind = ewfd_pkg::KIND_PAYLOAD;
        r.slot = packet_slot[ewfd_pkg::SLOT_OUT_W-1:0];
        r.position = kept_words[ewfd_pkg::POS_W-1:0];
        r.value = stored;
        produced = 1;
        kept_words = kept_words + 1'b1;
      end
    end
    if (produced) pending_results.push_back(r);
  endtask

  always @(posedge clk) begin
    deframe_result_t want;
    if (rst) begin
      link_mode = ACK_CODE_WAIT;
      packet_slot = 0;
      kept_words = '0;
      held_code = '0;
      length_limit = ewfd_pkg::MAX_LENGTH_RESET;
      pending_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result with nothing pending: kind %0d slot %0d", kind, slot);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("kind", want.kind, kind);
          check_field("slot", want.slot, slot);
          check_field("position", want.position, position);
          check_field("length", want.length, length);
          check_field("value", want.value, value);
          check_field("ack_code", want.ack_code, ack_code);
          check_field("ack_info", want.ack_info, ack_info);
        end
      end
      if (cfg_we) length_limit = cfg_data;
      if (in_valid && !in_stall) deframe_word(received_word);
    end
    drained <= (pending_results.size() == 0);
  end

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Escaped word frame deframer testbench
// Drives link words through the deframer: directed corner sequences first,
// then random framed packets, acknowledge pairs and noise under several
// max_length settings, with random idling on both channels. A checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;

  localparam int IDLE_LIMIT = 2000;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_we = 1'b0;
  logic [ewfd_pkg::LEN_W-1:0]      cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [ewfd_pkg::WORD_W-1:0]     received_word = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [ewfd_pkg::KIND_W-1:0]     kind;
  logic [ewfd_pkg::SLOT_OUT_W-1:0] slot;
  logic [ewfd_pkg::POS_W-1:0]      position;
  logic [ewfd_pkg::LEN_W-1:0]      length;
  logic [ewfd_pkg::WORD_W-1:0]     value;
  logic [ewfd_pkg::WORD_W-1:0]     ack_code;
  logic [ewfd_pkg::WORD_W-1:0]     ack_info;
  int                              fail_count;
  logic                            drained;

  int idle_pct = 25;
  int stall_pct = 25;
  int words_sent = 0;

  always #5 clk = ~clk;

  escaped_word_frame_deframer uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .received_word(received_word),
    .out_valid(out_valid), .out_stall(out_stall), .kind(kind), .slot(slot),
    .position(position), .length(length), .value(value),
    .ack_code(ack_code), .ack_info(ack_info)
  );

  escaped_word_frame_deframer_checker checker_i (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .received_word(received_word),
    .out_valid(out_valid), .out_stall(out_stall), .kind(kind), .slot(slot),
    .position(position), .length(length), .value(value),
    .ack_code(ack_code), .ack_info(ack_info),
    .fail_count(fail_count), .drained(drained)
  );

  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  // Each cycle before a word idles with the idle percentage, so idle
  // cycles make up about that share of the input cycles.
  task automatic send_word(input logic [ewfd_pkg::WORD_W-1:0] w);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    received_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (w != ewfd_pkg::WORD_IDLE) words_sent++;
  endtask

  // Mostly plain random words, with the link codes and extremes mixed in.
  function automatic logic [ewfd_pkg::WORD_W-1:0] pick_word();
    if ($urandom_range(99) >= 20) return ewfd_pkg::WORD_W'($urandom_range(0, 65535));
    case ($urandom_range(0, 6))
      0: return ewfd_pkg::WORD_IDLE;
      1: return ewfd_pkg::WORD_SOP;
      2: return ewfd_pkg::WORD_EOP;
      3: return ewfd_pkg::WORD_ESC;
      4: return 16'h0000;
      5: return 16'hFFFE;
      default: return ewfd_pkg::WORD_ESC ^ ewfd_pkg::ESC_FLIP;
    endcase
  endfunction

  // A well-formed encoder escapes every link code inside a packet, and
  // may escape any other word too.
  task automatic send_packet(input int n, input bit close);
    logic [ewfd_pkg::WORD_W-1:0] w;
    send_word(ewfd_pkg::WORD_SOP);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(19) == 0) send_word(ewfd_pkg::WORD_IDLE);
      w = ($urandom_range(99) < 15) ? pick_word()
                                    : ewfd_pkg::WORD_W'($urandom_range(0, 65535));
      if (w == ewfd_pkg::WORD_IDLE || w == ewfd_pkg::WORD_SOP ||
          w == ewfd_pkg::WORD_EOP || w == ewfd_pkg::WORD_ESC ||
          $urandom_range(9) == 0) begin
        send_word(ewfd_pkg::WORD_ESC);
        send_word(w ^ ewfd_pkg::ESC_FLIP);
      end else begin
        send_word(w);
      end
    end
    if (close) send_word(ewfd_pkg::WORD_EOP);
  endtask

  task automatic send_ack();
    logic [ewfd_pkg::WORD_W-1:0] w;
    for (int i = 0; i < 2; i++) begin
      w = pick_word();
      while (w == ewfd_pkg::WORD_IDLE || w == ewfd_pkg::WORD_SOP) w = pick_word();
      send_word(w);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (!drained) @(posedge clk);
    // Words that cause no result may still sit in the pipeline.
    repeat (4) @(posedge clk);
  endtask

  task automatic write_max_length(input logic [ewfd_pkg::LEN_W-1:0] v);
    drain_results();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic traffic_phase(input int limit_v, input int word_goal);
    int eff;
    int n;
    int choice;
    write_max_length(ewfd_pkg::LEN_W'(limit_v));
    eff = (limit_v > 1024) ? 1024 : limit_v;
    words_sent = 0;
    while (words_sent < word_goal) begin
      choice = $urandom_range(99);
      if (choice < 55) begin
        if ($urandom_range(9) == 0) n = $urandom_range(0, (eff < 62) ? eff + 2 : 64);
        else n = $urandom_range(0, 12);
        // Now and then a packet is left open and the next word runs into it.
        send_packet(n, $urandom_range(19) != 0);
      end else if (choice < 80) begin
        send_ack();
      end else begin
        send_word(pick_word());
      end
    end
  endtask

  initial begin
    int stuck;
    stuck = 0;
    while (stuck < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck = 0;
      else stuck++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Acknowledge pairs at the extremes, with link codes as plain words and
    // an idle word between the two halves.
    send_word(ewfd_pkg::WORD_IDLE);
    send_word(16'h0000);
    send_word(16'hFFFE);
    send_word(ewfd_pkg::WORD_EOP);
    send_word(ewfd_pkg::WORD_ESC);
    send_word(16'h1234);
    send_word(ewfd_pkg::WORD_IDLE);
    send_word(16'h5678);
    // A start marker cuts off a half-received acknowledge pair.
    send_word(16'hABCD);
    send_word(ewfd_pkg::WORD_SOP);
    send_word(16'h0000);
    send_word(ewfd_pkg::WORD_ESC);
    send_word(ewfd_pkg::WORD_IDLE);
    send_word(16'hBFFF);
    send_word(ewfd_pkg::WORD_ESC);
    send_word(ewfd_pkg::WORD_EOP);
    send_word(ewfd_pkg::WORD_ESC);
    send_word(ewfd_pkg::WORD_ESC);
    send_word(16'hFFFE);
    send_word(ewfd_pkg::WORD_EOP);
    // A start marker right after an escape still restarts the packet.
    send_word(ewfd_pkg::WORD_SOP);
    send_word(ewfd_pkg::WORD_ESC);
    send_word(ewfd_pkg::WORD_SOP);
    send_word(16'h0001);
    send_word(ewfd_pkg::WORD_EOP);
    send_word(ewfd_pkg::WORD_SOP);
    send_word(ewfd_pkg::WORD_EOP);

    // The longest packet under a setting above the buffer size, then the
    // smallest limits.
    write_max_length(11'h7FF);
    send_packet(1026, 1'b1);
    write_max_length(11'd1);
    send_packet(3, 1'b1);
    write_max_length(11'd0);
    send_packet(2, 1'b1);

    traffic_phase(5, 150);
    idle_pct = 0;
    stall_pct = 0;
    traffic_phase(16, 150);
    idle_pct = 25;
    stall_pct = 25;
    traffic_phase(1, 150);
    traffic_phase($urandom_range(1, 1024), 150);
    traffic_phase(3, 150);
    traffic_phase(400, 150);

    drain_results();
    repeat (6) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
